[design/one_wire_temperature_read_sequencer_macros.svh]
// ----------------------------------------------------------------------------
// One-wire temperature read sequencer: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_TEMPERATURE_READ_SEQUENCER_MACROS_SVH
`define ONE_WIRE_TEMPERATURE_READ_SEQUENCER_MACROS_SVH

// Check a condition whenever the trigger holds, in the same cycle.
`define OWT_ASSERT_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Check a condition in the cycle after the trigger holds.
`define OWT_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

[design/owtrs_pkg.sv]
// ----------------------------------------------------------------------------
// One-wire temperature read sequencer package
// Script opcodes, the fixed command script, register indexes and timing.
// ----------------------------------------------------------------------------
`default_nettype none

package owtrs_pkg;

	localparam int STEP_W     = 6;
	localparam int SCRIPT_LEN = 53;
	localparam int READ_BITS  = 16;
	localparam int READ_CNT_W = 5;
	localparam int TICK_W     = 20;
	localparam int WATCH_W    = 16;
	localparam int CFG_DATA_W = 20;

	// Fixed slot timings in microseconds
	localparam logic [TICK_W-1:0] W1_LOW_US     = 20'd10;
	localparam logic [TICK_W-1:0] W1_RECOVER_US = 20'd50;
	localparam logic [TICK_W-1:0] RD_LOW_US     = 20'd5;
	localparam logic [TICK_W-1:0] RD_SAMPLE_US  = 20'd5;
	localparam logic [TICK_W-1:0] TICK_MAX      = 20'hFFFFF;

	// Steps that send a one bit: 0xCC 0x44 then 0xCC 0xBE, LSB first
	localparam logic [63:0] W1_MASK = 64'h0000_000B_ECC1_1330;

	typedef enum logic [2:0] {
		OP_IDLE = 3'd0,
		OP_INIT = 3'd1,
		OP_W0   = 3'd2,
		OP_W1   = 3'd3,
		OP_READ = 3'd4,
		OP_WAIT = 3'd5,
		OP_CONV = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_START = 2'd1,
		FUNC_SUPER = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		CFG_TICK_US       = 3'd0,
		CFG_RESET_LOW     = 3'd1,
		CFG_PRES_SAMPLE   = 3'd2,
		CFG_RESET_SLOT    = 3'd3,
		CFG_WRITE0_LOW    = 3'd4,
		CFG_READ_RECOVER  = 3'd5,
		CFG_CONV_WAIT     = 3'd6,
		CFG_WATCH_PERIODS = 3'd7
	} cfg_idx_t;

	// Look up the opcode of one script step
	function automatic op_t script_op(input logic [STEP_W-1:0] step);
		op_t op;
		case (step) inside
			6'd0:                      op = OP_IDLE;
			6'd1, 6'd19:               op = OP_INIT;
			6'd18:                     op = OP_WAIT;
			[6'd2:6'd17], [6'd20:6'd35]: op = W1_MASK[step] ? OP_W1 : OP_W0;
			[6'd36:6'd51]:             op = OP_READ;
			6'd52:                     op = OP_CONV;
			default:                   op = OP_IDLE;
		endcase
		return op;
	endfunction

endpackage

`default_nettype wire

[design/one_wire_temperature_read_sequencer.sv]
// ----------------------------------------------------------------------------
// One-wire temperature read sequencer
// Tick-driven 1-Wire master that runs a fixed reset/skip/convert/read script.
// ----------------------------------------------------------------------------
// Each request on the slave stream is a fine tick with the sampled line level,
// a start command or a supervision tick, and gives exactly one result on the
// master stream with the line drive, status pulses and the last reading as
// sign plus magnitude. One request is taken every clock unless the master
// stream stalls; a request is registered in the input stage, then its result in
// the result register. The rate is set by the single state update pass, whose
// longest path is the 20 x 8 bit elapsed-time multiply and its compare against
// the selected slot duration. The configuration channel is always ready; the
// user must write it only while no request is in flight; the block does not check.
`default_nettype none

module one_wire_temperature_read_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] dq_in, [7:1] zero
	input  wire logic [1:0]  s_tuser,   // [1:0] func
	// master stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [0] dq_low, [1] busy_res, [2] done_res,
	                                    // [3] presence_seen, [4] timed_out,
	                                    // [16:5] temp_whole, [20:17] temp_frac,
	                                    // [21] temp_negative, [23:22] zero
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [owtrs_pkg::CFG_DATA_W-1:0] cfg_data
);

	import owtrs_pkg::*;

	// Configuration registers
	logic [7:0]         tick_us_q;
	logic [15:0]        reset_low_q;
	logic [9:0]         pres_sample_q;
	logic [9:0]         reset_slot_q;
	logic [7:0]         write0_low_q;
	logic [7:0]         read_recover_q;
	logic [TICK_W-1:0]  conv_wait_q;
	logic [WATCH_W-1:0] watch_periods_q;

	// Input stage
	logic        valid_s1;
	logic [1:0]  func_s1;
	logic        dq_s1;
	logic        advance;

	// Sequencer state
	logic [STEP_W-1:0]     step_q,  step_d;
	logic [1:0]            phase_q, phase_d;
	logic [TICK_W-1:0]     tick_q,  tick_d;
	logic [READ_CNT_W-1:0] bits_q,  bits_d;
	logic [READ_BITS-1:0]  read_q,  read_d;
	logic                  line_q,  line_d;
	logic                  pres_q,  pres_d;
	logic                  succ_q,  succ_d;
	logic                  wrun_q,  wrun_d;
	logic [WATCH_W-1:0]    wcnt_q,  wcnt_d;
	logic [READ_BITS:0]    res_q,   res_d;
	logic                  done_d,  tmo_d;

	// Datapath helpers
	op_t                   op;
	logic [TICK_W-1:0]     tick_inc;
	logic [WATCH_W-1:0]    wcnt_inc;
	logic [TICK_W-1:0]     dur;
	logic [9:0]            rest_us;
	logic [TICK_W+7:0]     elapsed;
	logic                  hit;
	logic [READ_BITS-1:0]  mag;

	// Result register
	logic        out_valid_q;
	logic [21:0] out_q;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {2'b00, out_q};

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_us_q       <= 8'd5;
			reset_low_q     <= 16'd500;
			pres_sample_q   <= 10'd130;
			reset_slot_q    <= 10'd570;
			write0_low_q    <= 8'd60;
			read_recover_q  <= 8'd45;
			conv_wait_q     <= 20'd750000;
			watch_periods_q <= 16'd200;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TICK_US:       tick_us_q       <= cfg_data[7:0];
				CFG_RESET_LOW:     reset_low_q     <= cfg_data[15:0];
				CFG_PRES_SAMPLE:   pres_sample_q   <= cfg_data[9:0];
				CFG_RESET_SLOT:    reset_slot_q    <= cfg_data[9:0];
				CFG_WRITE0_LOW:    write0_low_q    <= cfg_data[7:0];
				CFG_READ_RECOVER:  read_recover_q  <= cfg_data[7:0];
				CFG_CONV_WAIT:     conv_wait_q     <= cfg_data;
				CFG_WATCH_PERIODS: watch_periods_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Capture the incoming request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			dq_s1   <= s_tdata[0];
		end
	end

	// Select the duration that the current slot waits for
	always_comb begin
		rest_us = (reset_slot_q > pres_sample_q) ? (reset_slot_q - pres_sample_q) : 10'd0;
		dur     = W1_RECOVER_US;
		case (op)
			OP_WAIT: dur = conv_wait_q;
			OP_INIT: begin
				case (phase_q)
					2'd1:    dur = {4'd0, reset_low_q};
					2'd2:    dur = {10'd0, pres_sample_q};
					default: dur = {10'd0, rest_us};
				endcase
			end
			OP_W0:   dur = {12'd0, write0_low_q};
			OP_W1:   dur = (phase_q == 2'd1) ? W1_LOW_US : W1_RECOVER_US;
			OP_READ: begin
				case (phase_q)
					2'd1:    dur = RD_LOW_US;
					2'd2:    dur = RD_SAMPLE_US;
					default: dur = {12'd0, read_recover_q};
				endcase
			end
			default: dur = W1_RECOVER_US;
		endcase
	end

	assign op       = script_op(step_q);
	assign tick_inc = (tick_q == TICK_MAX) ? tick_q : tick_q + 20'd1;
	assign wcnt_inc = (wcnt_q == {WATCH_W{1'b1}}) ? wcnt_q : wcnt_q + 16'd1;
	assign elapsed  = tick_inc * tick_us_q;
	assign hit      = elapsed >= {8'd0, dur};
	assign mag      = read_q[READ_BITS-1] ? (~read_q + 16'd1) : read_q;

	// Compute the next sequencer state for one request
	always_comb begin
		step_d  = step_q;
		phase_d = phase_q;
		tick_d  = tick_q;
		bits_d  = bits_q;
		read_d  = read_q;
		line_d  = line_q;
		pres_d  = pres_q;
		succ_d  = succ_q;
		wrun_d  = wrun_q;
		wcnt_d  = wcnt_q;
		res_d   = res_q;
		done_d  = 1'b0;
		tmo_d   = 1'b0;
		if (advance) begin
			case (func_t'(func_s1))
				FUNC_TICK: begin
					if (op == OP_CONV) begin
						res_d   = {read_q[READ_BITS-1], mag};
						succ_d  = 1'b1;
						step_d  = '0;
						phase_d = 2'd0;
						done_d  = 1'b1;
					end else if (op != OP_IDLE) begin
						tick_d = tick_inc;
						if (op == OP_WAIT) begin
							if (hit) begin
								tick_d  = '0;
								phase_d = 2'd0;
								step_d  = step_q + 6'd1;
							end
						end else if (phase_q == 2'd0) begin
							// open the slot by pulling the line low
							line_d  = 1'b1;
							tick_d  = '0;
							phase_d = 2'd1;
						end else if (op == OP_W0) begin
							if (hit) begin
								line_d  = 1'b0;
								tick_d  = '0;
								phase_d = 2'd0;
								step_d  = step_q + 6'd1;
							end
						end else if (phase_q == 2'd1) begin
							// release the line after the low time
							if (hit) begin
								line_d  = 1'b0;
								tick_d  = '0;
								phase_d = 2'd2;
							end
						end else if (phase_q == 2'd2 && op == OP_INIT) begin
							// sample presence, retry while the line stays high
							if (hit) begin
								if (!dq_s1) begin
									pres_d  = 1'b1;
									tick_d  = '0;
									phase_d = 2'd3;
								end else begin
									pres_d = 1'b0;
								end
							end
						end else if (phase_q == 2'd2 && op == OP_READ) begin
							// sample one read bit, drop it once the word is full
							if (hit) begin
								if (bits_q < READ_CNT_W'(READ_BITS)) begin
									read_d[bits_q[3:0]] = dq_s1;
									bits_d = bits_q + 5'd1;
								end
								tick_d  = '0;
								phase_d = 2'd3;
							end
						end else if (hit) begin
							tick_d  = '0;
							phase_d = 2'd0;
							step_d  = step_q + 6'd1;
						end
					end
				end
				FUNC_START: begin
					step_d  = 6'd1;
					phase_d = 2'd0;
					bits_d  = '0;
					succ_d  = 1'b0;
					wrun_d  = 1'b1;
					wcnt_d  = '0;
				end
				FUNC_SUPER: begin
					if (wrun_q) begin
						wcnt_d = wcnt_inc;
						if (wcnt_inc >= watch_periods_q) begin
							// abort unless the read finished with a device present
							if (!(succ_q && pres_q)) begin
								step_d  = '0;
								phase_d = 2'd0;
								line_d  = 1'b0;
								tmo_d   = 1'b1;
							end
							wcnt_d = '0;
							wrun_d = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Hold sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			phase_q <= 2'd0;
			tick_q  <= '0;
			bits_q  <= '0;
			read_q  <= '0;
			line_q  <= 1'b0;
			pres_q  <= 1'b0;
			succ_q  <= 1'b0;
			wrun_q  <= 1'b0;
			wcnt_q  <= '0;
			res_q   <= '0;
		end else begin
			step_q  <= step_d;
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bits_q  <= bits_d;
			read_q  <= read_d;
			line_q  <= line_d;
			pres_q  <= pres_d;
			succ_q  <= succ_d;
			wrun_q  <= wrun_d;
			wcnt_q  <= wcnt_d;
			res_q   <= res_d;
		end
	end

	// Present the result of each request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= {res_d[READ_BITS], res_d[3:0], res_d[15:4],
			          tmo_d, pres_d, done_d, (step_d != '0), line_d};
		end
	end

`include "one_wire_temperature_read_sequencer_macros.svh"

	`OWT_ASSERT_SAME(a_done_not_tmo, m_tvalid, !(out_q[2] && out_q[4]), "done and timeout together")
	`OWT_ASSERT_SAME(a_done_idle, m_tvalid && out_q[2], !out_q[1], "busy after conversion")
	`OWT_ASSERT_SAME(a_tmo_release, m_tvalid && out_q[4], !out_q[1] && !out_q[0], "line held after abort")
	`OWT_ASSERT_SAME(a_step_range, 1'b1, step_q < STEP_W'(SCRIPT_LEN), "script step beyond script")
	`OWT_ASSERT_NEXT(a_bits_range, 1'b1, bits_q <= READ_CNT_W'(READ_BITS), "read count overflow")

endmodule

`default_nettype wire
